>>> rtl/hcic_pkg.sv
`default_nettype none

package hcic_pkg;

    localparam int COORD_W     = 16;
    localparam int INDEX_W     = 32;
    localparam int ORDER_W     = 5;
    localparam logic [ORDER_W-1:0] ORDER_RESET = 5'd3;

    // direction codes
    localparam logic FUNC_XY2D = 1'b0;
    localparam logic FUNC_D2XY = 1'b1;

    typedef struct packed {
        logic               func;
        logic [COORD_W-1:0] coord_y;
        logic [COORD_W-1:0] coord_x;
        logic [INDEX_W-1:0] curve_index;
    } t_cmd;

    typedef struct packed {
        logic [INDEX_W-1:0] index_out;
        logic [COORD_W-1:0] y_out;
        logic [COORD_W-1:0] x_out;
    } t_result;

    // one beat in flight along the cell chain
    typedef struct packed {
        logic               valid;
        logic               func;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] x;
        logic [INDEX_W-1:0] idx;
    } t_stage;

endpackage

`default_nettype wire

>>> rtl/hcic_cell.sv
`default_nettype none

module hcic_cell
    import hcic_pkg::*;
#(
    parameter int MAX_ORDER = 16,
    parameter int CELL_IDX  = 0
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [ORDER_W-1:0] i_order,
    input  wire t_stage             i_stage,
    output t_stage                  o_stage
);

    // forward walks top level first, reverse walks bottom level first
    localparam int FWD_LVL = MAX_ORDER - 1 - CELL_IDX;
    localparam int REV_LVL = CELL_IDX;
    localparam logic [ORDER_W-1:0] FWD_L = ORDER_W'(FWD_LVL);
    localparam logic [ORDER_W-1:0] REV_L = ORDER_W'(REV_LVL);
    localparam logic [COORD_W-1:0] REV_MASK = COORD_W'((1 << REV_LVL) - 1);

    t_stage r_stage;
    t_stage n_stage;

    logic rx;
    logic ry;

    // transform one level of the point or index
    always_comb begin
        n_stage = i_stage;
        rx      = 1'b0;
        ry      = 1'b0;
        if (i_stage.func == FUNC_XY2D) begin
            rx = i_stage.x[FWD_LVL];
            ry = i_stage.y[FWD_LVL];
            if (FWD_L < i_order) begin
                n_stage.idx[2*FWD_LVL+1] = rx;
                n_stage.idx[2*FWD_LVL]   = rx ^ ry;
                if (!ry) begin
                    if (rx) begin
                        n_stage.x = ~i_stage.y;
                        n_stage.y = ~i_stage.x;
                    end else begin
                        n_stage.x = i_stage.y;
                        n_stage.y = i_stage.x;
                    end
                end
            end
        end else begin
            rx = i_stage.idx[2*REV_LVL+1];
            ry = i_stage.idx[2*REV_LVL] ^ rx;
            if (REV_L < i_order) begin
                if (!ry) begin
                    if (rx) begin
                        n_stage.x = i_stage.y ^ REV_MASK;
                        n_stage.y = i_stage.x ^ REV_MASK;
                    end else begin
                        n_stage.x = i_stage.y;
                        n_stage.y = i_stage.x;
                    end
                end
                n_stage.x[REV_LVL] = rx;
                n_stage.y[REV_LVL] = ry;
            end
        end
    end

    // hand the beat to the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else begin
            r_stage.valid <= n_stage.valid;
        end
        r_stage.func <= n_stage.func;
        r_stage.y    <= n_stage.y;
        r_stage.x    <= n_stage.x;
        r_stage.idx  <= n_stage.idx;
    end

    assign o_stage = r_stage;

endmodule

`default_nettype wire

>>> rtl/hilbert_curve_index_convert_unit.sv
`default_nettype none

// Hilbert curve converter, point to distance (func 0) or distance to point
// (func 1) on a grid of side 2^grid_order. One cell per curve level, so a
// command may be started every cycle; busy stays low and the result strobe
// rises after the command has passed each cell register and the output
// register. Results are presented for one cycle only and cannot be held off.
// grid_order saturates to 1..MAX_ORDER; write it only while no command is in
// flight.

module hilbert_curve_index_convert_unit
    import hcic_pkg::*;
#(
    parameter int MAX_ORDER = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire t_cmd               i_cmd,
    output logic                    o_strobe,
    output t_result                 o_result,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [ORDER_W-1:0] i_cfg_data
);

    localparam logic [ORDER_W-1:0] MAX_L = ORDER_W'(MAX_ORDER);

    logic [ORDER_W-1:0] r_grid_order;
    logic [ORDER_W-1:0] eff_order;
    logic               accept;
    logic               r_strobe;
    t_result            r_result;
    t_result            n_result;
    t_stage             w_chain [MAX_ORDER+1];

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign accept      = start && !busy;

    // hold the order register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_order <= ORDER_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_grid_order <= i_cfg_data;
        end
    end

    // saturate the order to the supported range
    always_comb begin
        if (r_grid_order == '0) begin
            eff_order = ORDER_W'(1);
        end else if (r_grid_order > MAX_L) begin
            eff_order = MAX_L;
        end else begin
            eff_order = r_grid_order;
        end
    end

    // load the chain head; clear the fields the mode does not use
    always_comb begin
        w_chain[0].valid = accept;
        w_chain[0].func  = i_cmd.func;
        if (i_cmd.func == FUNC_XY2D) begin
            w_chain[0].y   = i_cmd.coord_y;
            w_chain[0].x   = i_cmd.coord_x;
            w_chain[0].idx = '0;
        end else begin
            w_chain[0].y   = '0;
            w_chain[0].x   = '0;
            w_chain[0].idx = i_cmd.curve_index;
        end
    end

    for (genvar i = 0; i < MAX_ORDER; i++) begin : g_cell
        hcic_cell #(
            .MAX_ORDER (MAX_ORDER),
            .CELL_IDX  (i)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_order (eff_order),
            .i_stage (w_chain[i]),
            .o_stage (w_chain[i+1])
        );
    end

    // select the result fields by mode
    always_comb begin
        if (w_chain[MAX_ORDER].func == FUNC_XY2D) begin
            n_result.index_out = w_chain[MAX_ORDER].idx;
            n_result.y_out     = '0;
            n_result.x_out     = '0;
        end else begin
            n_result.index_out = '0;
            n_result.y_out     = w_chain[MAX_ORDER].y;
            n_result.x_out     = w_chain[MAX_ORDER].x;
        end
    end

    // register the result beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= w_chain[MAX_ORDER].valid;
        end
        r_result <= n_result;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##(MAX_ORDER+1) o_strobe)
        else $error("result beat missing after start");

    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(accept, MAX_ORDER+1))
        else $error("result beat without a start");

    a_mode_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.index_out != '0) |->
            (o_result.x_out == '0 && o_result.y_out == '0))
        else $error("both result modes populated");

    a_order_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (eff_order != '0) && (eff_order <= MAX_L))
        else $error("effective order out of range");

endmodule

`default_nettype wire
